>>> rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ETD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ETD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/etdsp_pkg.sv
// Shared constants for the edge-timed dibit sampler.
package etdsp_pkg;

  localparam int DEF_HIST_BINS    = 9;
  localparam int DEF_WINDOW_WORDS = 2;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SLICE_TIME = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIST_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_PAT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_MASK   = 3'd5;

  localparam logic [15:0] RST_SLICE_TIME = 16'd188;
  localparam logic [15:0] RST_HIST_LOW   = 16'd188;
  localparam logic [15:0] RST_HIST_HIGH  = 16'd228;
  localparam logic [15:0] RST_BIN_WIDTH  = 16'd4;
  localparam logic [31:0] RST_PRE_PAT    = 32'h5555_5555;
  localparam logic [31:0] RST_PRE_MASK   = 32'hFFFF_FFFF;

  localparam logic [6:0] REPEAT_CAP = 7'd64;
  localparam logic [2:0] DIV_TOP_K  = 3'd6;

endpackage

>>> rtl/edge_timed_dibit_sampler_preamble.sv
// Top level: edge-interval dibit sampler with histogram and preamble correlator.
//
// channel  dir  handshake              payload
// in_      in   in_valid / in_ready    command, timestamp, level_low, level_high
// out_     out  out_valid / out_ready  accepted .. kept_top
// cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// For each beat, a shared compare-subtract unit runs up to 7 steps for the bin
// index and up to 7 for the slice count, the bin store takes a read and a write
// state, and the window shifter moves one pair per cycle.
// in_ready is high only when the sequencer is idle; a result waiting in the
// output register does not block the next input beat. Reset is synchronous;
// histogram bins have valid bits, so no clearing pass follows reset.
module edge_timed_dibit_sampler_preamble #(
  parameter int HIST_BINS    = etdsp_pkg::DEF_HIST_BINS,
  parameter int WINDOW_WORDS = etdsp_pkg::DEF_WINDOW_WORDS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [31:0]                    in_timestamp,
  input  logic                           in_level_low,
  input  logic                           in_level_high,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_accepted,
  output logic [6:0]                     out_repeat_count,
  output logic                           out_preamble_hit,
  output logic [31:0]                    out_match_total,
  output logic [31:0]                    out_edge_total,
  output logic [3:0]                     out_bin_code,
  output logic [31:0]                    out_bin_total,
  output logic [63:0]                    out_window_top,
  output logic [63:0]                    out_kept_top,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [etdsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int W_BITS = WINDOW_WORDS * 64;
  localparam int IDX_W  = (HIST_BINS > 1) ? $clog2(HIST_BINS) : 1;
  localparam logic [6:0] LAST_Q = 7'(HIST_BINS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HIST_BINS - 1);
  localparam logic [3:0] CODE_SHORT = 4'd0;
  localparam logic [3:0] CODE_LONG  = 4'(HIST_BINS + 1);
  localparam logic [3:0] CODE_NONE  = 4'(HIST_BINS + 2);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HIST  = 4'd1;
  localparam logic [3:0] S_DIV   = 4'd2;
  localparam logic [3:0] S_HRD   = 4'd3;
  localparam logic [3:0] S_HWR   = 4'd4;
  localparam logic [3:0] S_SPREP = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_CMP   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  // control and architectural state
  logic [3:0]           state_r, state_nxt;
  logic [15:0]          slice_r, slice_nxt, hlow_r, hlow_nxt;
  logic [15:0]          hhigh_r, hhigh_nxt, bwidth_r, bwidth_nxt;
  logic [31:0]          pat_r, pat_nxt, mask_r, mask_nxt;
  logic [31:0]          last_r, last_nxt;
  logic [W_BITS-1:0]    win_r, win_nxt;
  logic [63:0]          kept_r, kept_nxt;
  logic [31:0]          match_r, match_nxt;
  logic [31:0]          edge0_r, edge0_nxt, edge1_r, edge1_nxt;
  logic [31:0]          short_r, short_nxt, long_r, long_nxt;
  logic [HIST_BINS-1:0] hvalid_r, hvalid_nxt;
  logic                 ov_r, ov_nxt;

  // per-beat payload
  logic                 lo_r, lo_nxt, hi_r, hi_nxt;
  logic [31:0]          ts_r, ts_nxt, delta_r, delta_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [15:0]          div_r, div_nxt;
  logic [2:0]           k_r, k_nxt;
  logic [6:0]           q_r, q_nxt;
  logic                 dsel_r, dsel_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [6:0]           cnt_r, cnt_nxt;
  logic                 acc_r, acc_nxt, hit_r, hit_nxt;
  logic [6:0]           reps_r, reps_nxt;
  logic [3:0]           code_r, code_nxt;
  logic [31:0]          btot_r, btot_nxt, etot_r, etot_nxt;

  // output register
  logic                 o_acc_r, o_acc_nxt, o_hit_r, o_hit_nxt;
  logic [6:0]           o_reps_r, o_reps_nxt;
  logic [31:0]          o_match_r, o_match_nxt, o_etot_r, o_etot_nxt;
  logic [3:0]           o_code_r, o_code_nxt;
  logic [31:0]          o_btot_r, o_btot_nxt;
  logic [63:0]          o_win_r, o_win_nxt, o_kept_r, o_kept_nxt;

  // bin store
  logic [31:0]          hmem [HIST_BINS];
  logic [31:0]          hrd_r;
  logic                 hwe;
  logic [31:0]          hwdata;

  // shared compare-subtract unit
  logic [31:0]          cand;
  logic                 ge;
  logic [6:0]           q_fin, q_clamp;
  logic                 div_last;
  logic [15:0]          slice_eff;
  logic [31:0]          top32;
  logic                 in_fire;

  assign cand      = 32'(div_r) << k_r;
  assign ge        = rem_r >= cand;
  assign div_last  = (ge && (k_r == etdsp_pkg::DIV_TOP_K)) || (k_r == 3'd0);
  assign q_fin     = (ge && (k_r == etdsp_pkg::DIV_TOP_K)) ? etdsp_pkg::REPEAT_CAP :
                     (ge ? (q_r | (7'd1 << k_r)) : q_r);
  assign q_clamp   = (q_fin > LAST_Q) ? LAST_Q : q_fin;
  assign slice_eff = (slice_r == 16'd0) ? 16'd1 : slice_r;
  assign top32     = win_r[W_BITS-1 -: 32];
  assign hwe       = (state_r == S_HWR);
  assign hwdata    = hvalid_r[idx_r] ? (hrd_r + 32'd1) : 32'd1;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt  = state_r;
    slice_nxt  = slice_r;
    hlow_nxt   = hlow_r;
    hhigh_nxt  = hhigh_r;
    bwidth_nxt = bwidth_r;
    pat_nxt    = pat_r;
    mask_nxt   = mask_r;
    last_nxt   = last_r;
    win_nxt    = win_r;
    kept_nxt   = kept_r;
    match_nxt  = match_r;
    edge0_nxt  = edge0_r;
    edge1_nxt  = edge1_r;
    short_nxt  = short_r;
    long_nxt   = long_r;
    hvalid_nxt = hvalid_r;
    ov_nxt     = ov_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    ts_nxt     = ts_r;
    delta_nxt  = delta_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    k_nxt      = k_r;
    q_nxt      = q_r;
    dsel_nxt   = dsel_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    hit_nxt    = hit_r;
    reps_nxt   = reps_r;
    code_nxt   = code_r;
    btot_nxt   = btot_r;
    etot_nxt   = etot_r;
    o_acc_nxt   = o_acc_r;
    o_hit_nxt   = o_hit_r;
    o_reps_nxt  = o_reps_r;
    o_match_nxt = o_match_r;
    o_etot_nxt  = o_etot_r;
    o_code_nxt  = o_code_r;
    o_btot_nxt  = o_btot_r;
    o_win_nxt   = o_win_r;
    o_kept_nxt  = o_kept_r;

    if (cfg_valid) begin
      unique case (cfg_index)
        etdsp_pkg::REG_SLICE_TIME: slice_nxt  = cfg_data[15:0];
        etdsp_pkg::REG_HIST_LOW:   hlow_nxt   = cfg_data[15:0];
        etdsp_pkg::REG_HIST_HIGH:  hhigh_nxt  = cfg_data[15:0];
        etdsp_pkg::REG_BIN_WIDTH:  bwidth_nxt = cfg_data[15:0];
        etdsp_pkg::REG_PRE_PAT:    pat_nxt    = cfg_data;
        etdsp_pkg::REG_PRE_MASK:   mask_nxt   = cfg_data;
        default: ;
      endcase
    end

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          lo_nxt    = in_level_low;
          hi_nxt    = in_level_high;
          ts_nxt    = in_timestamp;
          delta_nxt = in_timestamp - last_r;
          acc_nxt   = 1'b0;
          hit_nxt   = 1'b0;
          reps_nxt  = 7'd0;
          code_nxt  = CODE_NONE;
          btot_nxt  = 32'd0;
          if (in_command) begin
            edge1_nxt = edge1_r + 32'd1;
            etot_nxt  = edge1_r + 32'd1;
            state_nxt = S_SPREP;
          end else begin
            edge0_nxt = edge0_r + 32'd1;
            etot_nxt  = edge0_r + 32'd1;
            state_nxt = S_HIST;
          end
        end
      end
      S_HIST: begin
        if (delta_r < 32'(hlow_r)) begin
          short_nxt = short_r + 32'd1;
          btot_nxt  = short_r + 32'd1;
          code_nxt  = CODE_SHORT;
          state_nxt = S_SPREP;
        end else if (delta_r > 32'(hhigh_r)) begin
          long_nxt  = long_r + 32'd1;
          btot_nxt  = long_r + 32'd1;
          code_nxt  = CODE_LONG;
          state_nxt = S_SPREP;
        end else if (bwidth_r == 16'd0) begin
          idx_nxt   = LAST_IDX;
          state_nxt = S_HRD;
        end else begin
          rem_nxt   = delta_r - 32'(hlow_r);
          div_nxt   = bwidth_r;
          k_nxt     = etdsp_pkg::DIV_TOP_K;
          q_nxt     = 7'd0;
          dsel_nxt  = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - cand;
        end
        q_nxt = q_fin;
        k_nxt = k_r - 3'd1;
        if (div_last) begin
          if (dsel_r) begin
            reps_nxt  = q_fin;
            cnt_nxt   = q_fin;
            state_nxt = S_SHIFT;
          end else begin
            idx_nxt   = IDX_W'(q_clamp);
            state_nxt = S_HRD;
          end
        end
      end
      S_HRD: begin
        state_nxt = S_HWR;
      end
      S_HWR: begin
        btot_nxt          = hwdata;
        code_nxt          = 4'(idx_r) + 4'd1;
        hvalid_nxt[idx_r] = 1'b1;
        state_nxt         = S_SPREP;
      end
      S_SPREP: begin
        if (delta_r >= 32'(slice_eff)) begin
          acc_nxt   = 1'b1;
          last_nxt  = ts_r;
          rem_nxt   = delta_r;
          div_nxt   = slice_eff;
          k_nxt     = etdsp_pkg::DIV_TOP_K;
          q_nxt     = 7'd0;
          dsel_nxt  = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (cnt_r != 7'd0) begin
          win_nxt = {win_r[W_BITS-3:0], lo_r, hi_r};
          cnt_nxt = cnt_r - 7'd1;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (((top32 ^ pat_r) & mask_r) == 32'd0) begin
          hit_nxt   = 1'b1;
          match_nxt = match_r + 32'd1;
          kept_nxt  = win_r[W_BITS-1 -: 64];
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt      = 1'b1;
          o_acc_nxt   = acc_r;
          o_hit_nxt   = hit_r;
          o_reps_nxt  = reps_r;
          o_match_nxt = match_r;
          o_etot_nxt  = etot_r;
          o_code_nxt  = code_r;
          o_btot_nxt  = btot_r;
          o_win_nxt   = win_r[W_BITS-1 -: 64];
          o_kept_nxt  = kept_r;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      slice_r  <= etdsp_pkg::RST_SLICE_TIME;
      hlow_r   <= etdsp_pkg::RST_HIST_LOW;
      hhigh_r  <= etdsp_pkg::RST_HIST_HIGH;
      bwidth_r <= etdsp_pkg::RST_BIN_WIDTH;
      pat_r    <= etdsp_pkg::RST_PRE_PAT;
      mask_r   <= etdsp_pkg::RST_PRE_MASK;
      last_r   <= '0;
      win_r    <= '0;
      kept_r   <= '0;
      match_r  <= '0;
      edge0_r  <= '0;
      edge1_r  <= '0;
      short_r  <= '0;
      long_r   <= '0;
      hvalid_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      slice_r  <= slice_nxt;
      hlow_r   <= hlow_nxt;
      hhigh_r  <= hhigh_nxt;
      bwidth_r <= bwidth_nxt;
      pat_r    <= pat_nxt;
      mask_r   <= mask_nxt;
      last_r   <= last_nxt;
      win_r    <= win_nxt;
      kept_r   <= kept_nxt;
      match_r  <= match_nxt;
      edge0_r  <= edge0_nxt;
      edge1_r  <= edge1_nxt;
      short_r  <= short_nxt;
      long_r   <= long_nxt;
      hvalid_r <= hvalid_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    ts_r      <= ts_nxt;
    delta_r   <= delta_nxt;
    rem_r     <= rem_nxt;
    div_r     <= div_nxt;
    k_r       <= k_nxt;
    q_r       <= q_nxt;
    dsel_r    <= dsel_nxt;
    idx_r     <= idx_nxt;
    cnt_r     <= cnt_nxt;
    acc_r     <= acc_nxt;
    hit_r     <= hit_nxt;
    reps_r    <= reps_nxt;
    code_r    <= code_nxt;
    btot_r    <= btot_nxt;
    etot_r    <= etot_nxt;
    o_acc_r   <= o_acc_nxt;
    o_hit_r   <= o_hit_nxt;
    o_reps_r  <= o_reps_nxt;
    o_match_r <= o_match_nxt;
    o_etot_r  <= o_etot_nxt;
    o_code_r  <= o_code_nxt;
    o_btot_r  <= o_btot_nxt;
    o_win_r   <= o_win_nxt;
    o_kept_r  <= o_kept_nxt;
  end

  // bin store: one write port, registered read
  always_ff @(posedge clk) begin
    if (hwe) begin
      hmem[idx_r] <= hwdata;
    end
    hrd_r <= hmem[idx_r];
  end

  assign out_valid        = ov_r;
  assign out_accepted     = o_acc_r;
  assign out_repeat_count = o_reps_r;
  assign out_preamble_hit = o_hit_r;
  assign out_match_total  = o_match_r;
  assign out_edge_total   = o_etot_r;
  assign out_bin_code     = o_code_r;
  assign out_bin_total    = o_btot_r;
  assign out_window_top   = o_win_r;
  assign out_kept_top     = o_kept_r;

endmodule

>>> rtl/etdsp_checker.sv
// Port-level checker for the edge-timed dibit sampler, with its bind.
`include "assert_macros.svh"

module etdsp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            in_command,
  input logic [31:0]                     in_timestamp,
  input logic                            in_level_low,
  input logic                            in_level_high,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_accepted,
  input logic [6:0]                      out_repeat_count,
  input logic                            out_preamble_hit,
  input logic [31:0]                     out_match_total,
  input logic [31:0]                     out_edge_total,
  input logic [3:0]                      out_bin_code,
  input logic [31:0]                     out_bin_total,
  input logic [63:0]                     out_window_top,
  input logic [63:0]                     out_kept_top,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [etdsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                     cfg_data
);

  `ETD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_edge_total) && $stable(out_window_top), "result beat changed while stalled")
  `ETD_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "input taken while a beat is in work")
  `ETD_ASSERT(a_reject_empty, out_valid && !out_accepted |-> out_repeat_count == 7'd0 && !out_preamble_hit, "rejected edge reports shifts or a hit")
  `ETD_ASSERT(a_reps_range, out_valid && out_accepted |-> out_repeat_count != 7'd0 && out_repeat_count <= etdsp_pkg::REPEAT_CAP, "pair count out of range")
  `ETD_ASSERT(a_hit_kept, out_valid && out_preamble_hit |-> out_kept_top == out_window_top, "kept copy differs from window on a hit")

endmodule

bind edge_timed_dibit_sampler_preamble etdsp_checker u_etdsp_checker (.*);

>>> verif/tb_edge_timed_dibit_sampler_preamble.sv
// Self-checking testbench for the edge-timed dibit sampler with preamble correlator.
module tb_edge_timed_dibit_sampler_preamble;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_BINS = etdsp_pkg::DEF_HIST_BINS;
  localparam int WIN_BITS = 64 * etdsp_pkg::DEF_WINDOW_WORDS;
  localparam int IDX_W = etdsp_pkg::CFG_IDX_W;
  localparam bit LINE_ZERO = 1'b0;
  localparam bit LINE_TWO = 1'b1;
  localparam logic [3:0] BIN_FAR_LEFT = 4'd0;
  localparam logic [3:0] BIN_FAR_RIGHT = 4'(HIST_BINS + 1);
  localparam logic [3:0] BIN_UNSORTED = 4'(HIST_BINS + 2);
  localparam int PHASES = 8;
  localparam int PHASE_BEATS = 155;
  localparam int DRAIN_AT = 600;
  localparam int DRAIN_CYCLES = 90;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    bit        command;
    bit [31:0] stamp;
    bit        lvl_lo;
    bit        lvl_hi;
  } edge_beat_t;

  typedef struct {
    logic        accepted;
    logic [6:0]  repeat_count;
    logic        preamble_hit;
    logic [31:0] match_total;
    logic [31:0] edge_total;
    logic [3:0]  bin_code;
    logic [31:0] bin_total;
    logic [63:0] window_top;
    logic [63:0] kept_top;
  } sample_t;

  class dibit_scoreboard;
    bit [15:0] slice_time, hist_low, hist_high, bin_width;
    bit [31:0] pattern, mask;
    bit [31:0] last_stamp, match_cnt, short_cnt, long_cnt;
    bit [31:0] edge_cnt [2];
    bit [31:0] hist [HIST_BINS];
    bit [WIN_BITS-1:0] window, kept;
    sample_t predicted_samples[$];
    int fails;
    int checked;

    function new();
      slice_time = etdsp_pkg::RST_SLICE_TIME;
      hist_low = etdsp_pkg::RST_HIST_LOW;
      hist_high = etdsp_pkg::RST_HIST_HIGH;
      bin_width = etdsp_pkg::RST_BIN_WIDTH;
      pattern = etdsp_pkg::RST_PRE_PAT;
      mask = etdsp_pkg::RST_PRE_MASK;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        etdsp_pkg::REG_SLICE_TIME: slice_time = data[15:0];
        etdsp_pkg::REG_HIST_LOW:   hist_low = data[15:0];
        etdsp_pkg::REG_HIST_HIGH:  hist_high = data[15:0];
        etdsp_pkg::REG_BIN_WIDTH:  bin_width = data[15:0];
        etdsp_pkg::REG_PRE_PAT:    pattern = data;
        etdsp_pkg::REG_PRE_MASK:   mask = data;
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted beat and queues it.
    function void note_edge(edge_beat_t b);
      sample_t s;
      bit [31:0] delta, slice, idx, reps, top;
      delta = b.stamp - last_stamp;
      slice = (slice_time == 0) ? 32'd1 : 32'(slice_time);
      s = '{default: '0};
      s.bin_code = BIN_UNSORTED;
      edge_cnt[b.command]++;
      if (b.command == LINE_ZERO) begin
        if (delta < hist_low) begin
          short_cnt++;
          s.bin_code = BIN_FAR_LEFT;
          s.bin_total = short_cnt;
        end else if (delta > hist_high) begin
          long_cnt++;
          s.bin_code = BIN_FAR_RIGHT;
          s.bin_total = long_cnt;
        end else begin
          idx = (bin_width == 0) ? HIST_BINS - 1 : (delta - hist_low) / bin_width;
          if (idx > HIST_BINS - 1) idx = HIST_BINS - 1;
          hist[idx]++;
          s.bin_code = 4'(idx + 1);
          s.bin_total = hist[idx];
        end
      end
      if (delta >= slice) begin
        s.accepted = 1'b1;
        last_stamp = b.stamp;
        reps = delta / slice;
        if (reps > 32'(etdsp_pkg::REPEAT_CAP)) reps = 32'(etdsp_pkg::REPEAT_CAP);
        repeat (reps) window = {window[WIN_BITS-3:0], b.lvl_lo, b.lvl_hi};
        s.repeat_count = reps[6:0];
        top = window[WIN_BITS-1 -: 32];
        if ((top & mask) == (pattern & mask)) begin
          s.preamble_hit = 1'b1;
          match_cnt++;
          kept = window;
        end
      end
      s.match_total = match_cnt;
      s.edge_total = edge_cnt[b.command];
      s.window_top = window[WIN_BITS-1 -: 64];
      s.kept_top = kept[WIN_BITS-1 -: 64];
      predicted_samples.push_back(s);
    endfunction

    task report(string msg);
      fails++;
      $display("MISMATCH %s", msg);
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, expected %0h", checked, name, got, want));
    endtask

    task check_sample(sample_t got);
      sample_t want;
      checked++;
      if (predicted_samples.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending", checked));
        return;
      end
      want = predicted_samples.pop_front();
      compare_field("accepted", 64'(got.accepted), 64'(want.accepted));
      compare_field("repeat_count", 64'(got.repeat_count), 64'(want.repeat_count));
      compare_field("preamble_hit", 64'(got.preamble_hit), 64'(want.preamble_hit));
      compare_field("match_total", 64'(got.match_total), 64'(want.match_total));
      compare_field("edge_total", 64'(got.edge_total), 64'(want.edge_total));
      compare_field("bin_code", 64'(got.bin_code), 64'(want.bin_code));
      compare_field("bin_total", 64'(got.bin_total), 64'(want.bin_total));
      compare_field("window_top", got.window_top, want.window_top);
      compare_field("kept_top", got.kept_top, want.kept_top);
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_command;
  logic [31:0]          in_timestamp;
  logic                 in_level_low;
  logic                 in_level_high;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_accepted;
  logic [6:0]           out_repeat_count;
  logic                 out_preamble_hit;
  logic [31:0]          out_match_total;
  logic [31:0]          out_edge_total;
  logic [3:0]           out_bin_code;
  logic [31:0]          out_bin_total;
  logic [63:0]          out_window_top;
  logic [63:0]          out_kept_top;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     cfg_index;
  logic [31:0]          cfg_data;

  dibit_scoreboard sb = new();
  sample_t seen;
  int beats_sent;
  int burst_left;
  int idle_cycles;

  edge_timed_dibit_sampler_preamble DUT (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen = '{out_accepted, out_repeat_count, out_preamble_hit, out_match_total,
               out_edge_total, out_bin_code, out_bin_total, out_window_top, out_kept_top};
      sb.check_sample(seen);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: ready pattern switches among random modes; one long hold-off.
  initial begin
    int mode;
    int span;
    bit [31:0] pat;
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 256);
      pat = $urandom;
      repeat (span) begin
        @(posedge clk);
        if (!hold_done && sb.checked >= HOLD_AFTER) begin
          hold_done = 1'b1;
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end else begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: begin
              out_ready <= pat[0];
              pat = {pat[0], pat[31:1]};
            end
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  task automatic offer(edge_beat_t b);
    in_valid <= 1'b1;
    in_command <= b.command;
    in_timestamp <= b.stamp;
    in_level_low <= b.lvl_lo;
    in_level_high <= b.lvl_hi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_edge(b);
    beats_sent++;
    burst_left--;
    if (beats_sent == DRAIN_AT) begin
      in_valid <= 1'b0;
      while (sb.predicted_samples.size() != 0) @(posedge clk);
    end else if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  endtask

  task automatic edge_after(bit cmd, bit [31:0] delta, bit lo, bit hi);
    offer('{cmd, sb.last_stamp + delta, lo, hi});
  endtask

  function automatic bit random_line();
    return ($urandom_range(0, 3) == 0) ? LINE_TWO : LINE_ZERO;
  endfunction

  task automatic noise_beat();
    bit [31:0] slice_eff, span, d;
    slice_eff = (sb.slice_time == 0) ? 32'd1 : 32'(sb.slice_time);
    span = (sb.hist_high > sb.hist_low) ? 32'(sb.hist_high - sb.hist_low) : 32'd0;
    case ($urandom_range(0, 5))
      0: d = $urandom_range(0, slice_eff - 1);
      1: d = slice_eff * $urandom_range(1, 70) + $urandom_range(0, slice_eff - 1);
      2: d = sb.hist_low + $urandom_range(0, 2) - 1;
      3: d = sb.hist_high + $urandom_range(0, 2) - 1;
      4: d = $urandom;
      default: d = sb.hist_low + $urandom_range(0, span);
    endcase
    edge_after(random_line(), d, 1'($urandom), 1'($urandom));
  endtask

  // Sixteen one-slice beats spell a pattern, then 48 more pairs push it to the top.
  task automatic preamble_run();
    bit [31:0] slice_eff, seq_pat;
    int cut;
    slice_eff = (sb.slice_time == 0) ? 32'd1 : 32'(sb.slice_time);
    seq_pat = ($urandom_range(0, 4) != 0) ? sb.pattern : $urandom;
    cut = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : -1;
    for (int j = 0; j < 16; j++) begin
      if (j == cut) noise_beat();
      edge_after(random_line(), slice_eff + $urandom_range(0, slice_eff - 1),
                 seq_pat[31-2*j], seq_pat[30-2*j]);
    end
    if (cut == 16) noise_beat();
    edge_after(random_line(), 48 * slice_eff + $urandom_range(0, slice_eff - 1),
               1'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(bit [15:0] slice, bit [15:0] lo, bit [15:0] hi,
                              bit [15:0] bw, bit [31:0] pat, bit [31:0] msk);
    write_reg(etdsp_pkg::REG_SLICE_TIME, {16'h0, slice});
    write_reg(etdsp_pkg::REG_HIST_LOW, {16'h0, lo});
    write_reg(etdsp_pkg::REG_HIST_HIGH, {16'h0, hi});
    write_reg(etdsp_pkg::REG_BIN_WIDTH, {16'h0, bw});
    write_reg(etdsp_pkg::REG_PRE_PAT, pat);
    write_reg(etdsp_pkg::REG_PRE_MASK, msk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.predicted_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int target;
    bit [15:0] slice, lo;
    in_valid <= 1'b0;
    in_command <= LINE_ZERO;
    in_timestamp <= '0;
    in_level_low <= 1'b0;
    in_level_high <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= etdsp_pkg::REG_SLICE_TIME;
    cfg_data <= '0;
    rst_n <= 1'b0;
    beats_sent = 0;
    burst_left = $urandom_range(1, 40);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: short intervals, histogram range edges, clamped bins, saturation, wrap.
    offer('{LINE_ZERO, 32'h0, 1'b0, 1'b0});
    edge_after(LINE_TWO, 100, 1'b1, 1'b1);
    edge_after(LINE_ZERO, 187, 1'b0, 1'b1);
    edge_after(LINE_ZERO, 188, 1'b0, 1'b1);
    edge_after(LINE_ZERO, 223, 1'b1, 1'b0);
    edge_after(LINE_ZERO, 224, 1'b1, 1'b1);
    edge_after(LINE_ZERO, 228, 1'b0, 1'b0);
    edge_after(LINE_ZERO, 229, 1'b0, 1'b1);
    edge_after(LINE_TWO, 64 * 188, 1'b0, 1'b1);
    edge_after(LINE_ZERO, 200 * 188, 1'b1, 1'b0);
    edge_after(LINE_ZERO, 63 * 188 + 187, 1'b0, 1'b1);
    offer('{LINE_ZERO, 32'hFFFF_FFF0, 1'b1, 1'b1});
    offer('{LINE_TWO, 32'h0000_0100, 1'b0, 1'b1});
    edge_after(LINE_ZERO, 32'hFFFF_FFFF, 1'b1, 1'b0);

    // Zero slice acts as one, zero bin width lands in the last bin.
    settle();
    program_regs(16'd0, 16'd0, 16'd10, 16'd0, etdsp_pkg::RST_PRE_PAT,
                 etdsp_pkg::RST_PRE_MASK);
    edge_after(LINE_ZERO, 0, 1'b0, 1'b1);
    edge_after(LINE_ZERO, 1, 1'b1, 1'b0);
    edge_after(LINE_ZERO, 11, 1'b0, 1'b0);
    edge_after(LINE_TWO, 70, 1'b1, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: program_regs(etdsp_pkg::RST_SLICE_TIME, etdsp_pkg::RST_HIST_LOW,
                        etdsp_pkg::RST_HIST_HIGH, etdsp_pkg::RST_BIN_WIDTH,
                        etdsp_pkg::RST_PRE_PAT, etdsp_pkg::RST_PRE_MASK);
        1: program_regs(16'd1, 16'd0, 16'hFFFF, 16'd1, $urandom, 32'h0);
        2: program_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: program_regs(16'd2, 16'd0, 16'd0, 16'd0, 32'h0, $urandom);
        default: begin
          slice = 16'($urandom_range(1, 600));
          lo = 16'($urandom_range(0, 2 * slice));
          program_regs(slice, lo, lo + 16'($urandom_range(0, 300)),
                       16'($urandom_range(0, 40)), $urandom, $urandom & $urandom);
        end
      endcase
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        if ($urandom_range(0, 9) < 6) preamble_run();
        else noise_beat();
      end
    end

    settle();
    if (sb.fails == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/etdsp_pkg.sv
rtl/edge_timed_dibit_sampler_preamble.sv
rtl/etdsp_checker.sv
verif/tb_edge_timed_dibit_sampler_preamble.sv
